// ===== rtl/core/mtf_pkg.sv =====
// Shared types and constants of the move-to-front codec.
// Holds the alphabet size, the field widths and the token that walks the cell chain.
// No dependencies.
package mtf_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int SYM_W         = 8;
  localparam int IDX_W         = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;

  typedef struct packed {
    logic             valid;
    logic             write;
    logic             hit;
    logic [SYM_W-1:0] key;
    logic [SYM_W-1:0] carry;
    logic [IDX_W-1:0] rank;
  } mtf_tok_t;

endpackage

// ===== rtl/core/mtf_cell.sv =====
// One entry of the recency list, holding a byte and the token stage next to it.
// Depends on mtf_pkg for the token type and widths.
module mtf_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load_identity,
  input  logic [mtf_pkg::IDX_W-1:0] index,
  input  mtf_pkg::mtf_tok_t       tok_in,
  output mtf_pkg::mtf_tok_t       tok_out
);

  logic [mtf_pkg::SYM_W-1:0] entry;
  logic [mtf_pkg::SYM_W-1:0] entry_next;
  mtf_pkg::mtf_tok_t         tok_next;

  always_comb begin
    entry_next = entry;
    tok_next   = tok_in;
    if (tok_in.valid && !tok_in.hit) begin
      if (tok_in.write) begin
        // take the displaced byte, pass ours on until the key is met
        entry_next = tok_in.carry;
        if (entry == tok_in.key) begin
          tok_next.hit  = 1'b1;
          tok_next.rank = index;
        end else begin
          tok_next.carry = entry;
        end
      end else if (index == tok_in.key[mtf_pkg::IDX_W-1:0]) begin
        tok_next.hit   = 1'b1;
        tok_next.carry = entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || load_identity) begin
      entry <= mtf_pkg::SYM_W'(index);
    end else begin
      entry <= entry_next;
    end
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== rtl/core/move_to_front_codec.sv =====
// Byte-wise move-to-front codec: a chain of ALPHABET_SIZE list cells walked by one token.
// Encoding runs one token pass down the cell chain; decoding runs a read pass, then a move
// pass. A new input transaction is taken only in the idle state: in_stall holds off the next
// one until the last result has been moved to the output register.
// Reset loads the identity list into every cell at once and sets mode to encode.
// Depends on mtf_pkg and mtf_cell.
module move_to_front_codec (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [mtf_pkg::SYM_W-1:0] symbol_in,
  input  logic                      new_stream,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mtf_pkg::SYM_W-1:0] symbol_out
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t                    state;
  logic                      mode;
  logic [mtf_pkg::SYM_W-1:0] sym_q;
  logic [mtf_pkg::SYM_W-1:0] result_q;
  logic                      in_range;
  logic                      load_identity;
  mtf_pkg::mtf_tok_t         launch_tok;
  mtf_pkg::mtf_tok_t         tail;
  mtf_pkg::mtf_tok_t         link [mtf_pkg::ALPHABET_SIZE+1];

  assign in_stall      = (state != S_IDLE);
  assign in_range      = ({1'b0, symbol_in} < (mtf_pkg::SYM_W+1)'(mtf_pkg::ALPHABET_SIZE));
  assign load_identity = in_valid && (state == S_IDLE) && new_stream;
  assign tail          = link[mtf_pkg::ALPHABET_SIZE];

  always_comb begin
    launch_tok = '0;
    if (state == S_LAUNCH) begin
      launch_tok.valid = 1'b1;
      launch_tok.write = !mode;
      launch_tok.key   = sym_q;
      launch_tok.carry = sym_q;
    end else if (state == S_SWEEP && tail.valid && !tail.write) begin
      // decoded byte found: send it back to the front
      launch_tok.valid = 1'b1;
      launch_tok.write = 1'b1;
      launch_tok.key   = tail.carry;
      launch_tok.carry = tail.carry;
    end
  end

  assign link[0] = launch_tok;

  for (genvar g = 0; g < mtf_pkg::ALPHABET_SIZE; g++) begin : g_cell
    mtf_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .load_identity (load_identity),
      .index         (mtf_pkg::IDX_W'(g)),
      .tok_in        (link[g]),
      .tok_out       (link[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mode      <= 1'b0;
    end else begin
      if (cfg_write) begin
        mode <= cfg_data;
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sym_q    <= symbol_in;
            result_q <= symbol_in;
            state    <= in_range ? S_LAUNCH : S_DONE;
          end
        end
        S_LAUNCH: begin
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          if (tail.valid) begin
            if (!tail.write) begin
              result_q <= tail.carry;
            end else begin
              if (!mode) begin
                result_q <= mtf_pkg::SYM_W'(tail.rank);
              end
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            symbol_out <= result_q;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_tail_hit: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> tail.hit)
    else $error("token left the chain without finding its entry");

  a_idle_no_token: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !tail.valid)
    else $error("token still in the chain while idle");

  a_single_token: assert property (@(posedge clk) disable iff (rst)
    tail.valid |=> !tail.valid)
    else $error("two tokens in the chain back to back");

endmodule
